// ----- rtl/dmlc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmlc_pkg: shared definitions for the map-list checker
// Status codes, register indexes, seen-mask bit positions and the type decode.
// ----------------------------------------------------------------------------
package dmlc_pkg;

  localparam int TYPE_W   = 16;
  localparam int COUNT_W  = 32;
  localparam int OFFS_W   = 32;
  localparam int STATUS_W = 4;
  localparam int SEEN_W   = 18;
  localparam int ID_N     = 6;

  localparam int IN_DATA_W  = 80;  // type + items + offset, whole bytes already
  localparam int OUT_DATA_W = 24;  // status + seen mask, padded to whole bytes

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_FILE_SIZE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DATA_SIZE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ID_DECL   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK            = 4'd0;
  localparam logic [STATUS_W-1:0] ST_ORDER         = 4'd1;
  localparam logic [STATUS_W-1:0] ST_PAST_END      = 4'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY      = 4'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN       = 4'd4;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE     = 4'd5;
  localparam logic [STATUS_W-1:0] ST_MISS_HEADER   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_MISS_MAP      = 4'd7;
  localparam logic [STATUS_W-1:0] ST_MISS_ID0      = 4'd8;
  localparam logic [STATUS_W-1:0] ST_MISS_CLASSDEF = 4'd13;

  localparam int SEEN_HEADER = 0;
  localparam int SEEN_ID0    = 1;
  localparam int SEEN_MAP    = 7;

  localparam logic [TYPE_W-1:0] CODE_LAST_ID = 16'h0006;
  localparam logic [TYPE_W-1:0] CODE_MAP     = 16'h1000;
  localparam logic [TYPE_W-1:0] CODE_DATA0   = 16'h2000;
  localparam logic [TYPE_W-1:0] CODE_DATA6   = 16'h2006;

  // One-hot seen-mask bit for a type code, zero for an unknown code.
  function automatic logic [SEEN_W-1:0] type_bit(input logic [TYPE_W-1:0] code);
    logic [SEEN_W-1:0] one;
    logic [SEEN_W-1:0] res;
    one = SEEN_W'(1);
    res = '0;
    if (code <= CODE_LAST_ID) begin
      res = one << code[2:0];
    end else if (code[TYPE_W-1:2] == CODE_MAP[TYPE_W-1:2]) begin
      res = one << (5'd7 + {3'd0, code[1:0]});
    end else if (code >= CODE_DATA0 && code <= CODE_DATA6) begin
      res = one << (5'd11 + {2'd0, code[2:0]});
    end
    return res;
  endfunction

endpackage

// ----- rtl/dex_map_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dex_map_list_checker: streaming validator for dex map-list entries
// Checks order, bounds, data budget, type codes and required sections.
// ----------------------------------------------------------------------------
// Usage:
//   Present map-list entries on the in_ stream, one request per entry, with
//   in_tlast on the last entry of a list. Every entry yields one result on the
//   out_ stream: the status (first error held for the rest of the list), the
//   mask of sections seen so far, and out_tlast marking the verdict on a list.
//   Program file_size, data_size and declared_id_sections through the cfg_
//   port while the block is idle; data_size is sampled at each list's first
//   entry.
//   The result passes through the input register, then the result register.
//   Throughput: one entry per cycle while the receiver does not stall; the
//   per-entry compares, the budget subtract and the mask update all sit in
//   the single stage between the two registers.
//   Reset (rst_n low, synchronous) empties both registers, clears the list
//   state and returns the configuration registers to zero.
//   When the receiver stalls, hold the result; the input register still takes
//   one more request, then in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module dex_map_list_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: section_type[15:0], section_items[47:16], byte_offset[79:48]
  input  logic [dmlc_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,   // final_entry
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata: status[3:0], sections_seen[21:4], zero[23:22]
  output logic [dmlc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,  // list_done
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [dmlc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dmlc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dmlc_pkg::*;

  // Configuration registers
  logic [OFFS_W-1:0]  file_size_r;
  logic [COUNT_W-1:0] data_size_r;
  logic [ID_N-1:0]    id_decl_r;

  // Input register
  logic               s1_valid_r;
  logic [TYPE_W-1:0]  s1_type_r;
  logic [COUNT_W-1:0] s1_items_r;
  logic [OFFS_W-1:0]  s1_offset_r;
  logic               s1_last_r;

  // List state
  logic [OFFS_W-1:0]   prev_offset_r,  prev_offset_nxt;
  logic [COUNT_W-1:0]  budget_r,       budget_nxt;
  logic [SEEN_W-1:0]   seen_mask_r,    seen_mask_nxt;
  logic                at_first_r,     at_first_nxt;
  logic [STATUS_W-1:0] held_error_r,   held_error_nxt;

  // Result register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r,   out_status_nxt;
  logic [SEEN_W-1:0]   out_seen_r;
  logic                out_last_r;

  logic                load;
  logic [SEEN_W-1:0]   bit_sel;
  logic                is_data;
  logic [COUNT_W-1:0]  budget_cur;
  logic [STATUS_W-1:0] entry_err;
  logic [SEEN_W-1:0]   seen_upd;
  logic [STATUS_W-1:0] miss_err;
  logic                miss_found;

  // Move the held entry into the result register when that register frees up.
  assign load      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || load;

  // Configuration writes; unused index values are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r <= '0;
      data_size_r <= '0;
      id_decl_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FILE_SIZE: file_size_r <= cfg_wdata;
        REG_DATA_SIZE: data_size_r <= cfg_wdata;
        REG_ID_DECL:   id_decl_r   <= cfg_wdata[ID_N-1:0];
        default:       ;
      endcase
    end
  end

  // Input register: take a request whenever the slot is free or draining.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_type_r   <= in_tdata[15:0];
      s1_items_r  <= in_tdata[47:16];
      s1_offset_r <= in_tdata[79:48];
      s1_last_r   <= in_tlast;
    end
  end

  // Per-entry checks, in priority order.
  assign bit_sel    = type_bit(s1_type_r);
  assign is_data    = s1_type_r > CODE_LAST_ID;
  assign budget_cur = at_first_r ? data_size_r : budget_r;

  always_comb begin
    entry_err = ST_OK;
    if (!at_first_r && prev_offset_r >= s1_offset_r) begin
      entry_err = ST_ORDER;
    end else if (s1_offset_r >= file_size_r) begin
      entry_err = ST_PAST_END;
    end else if (is_data && s1_items_r > budget_cur) begin
      entry_err = ST_TOO_MANY;
    end else if (bit_sel == '0) begin
      entry_err = ST_UNKNOWN;
    end else if ((seen_mask_r & bit_sel) != '0) begin
      entry_err = ST_DUPLICATE;
    end
  end

  // Mask as it stands after this entry (only grows on a clean entry).
  assign seen_upd = (held_error_r == ST_OK && entry_err == ST_OK) ?
                    (seen_mask_r | bit_sel) : seen_mask_r;

  // Required sections at the end of a list, first missing one wins.
  always_comb begin
    miss_err   = ST_OK;
    miss_found = 1'b0;
    if (!seen_upd[SEEN_HEADER]) begin
      miss_err   = ST_MISS_HEADER;
      miss_found = 1'b1;
    end else if (!seen_upd[SEEN_MAP]) begin
      miss_err   = ST_MISS_MAP;
      miss_found = 1'b1;
    end
    for (int k = 0; k < ID_N; k++) begin
      if (!miss_found && id_decl_r[k] && !seen_upd[SEEN_ID0 + k]) begin
        miss_err   = ST_MISS_ID0 + STATUS_W'(k);
        miss_found = 1'b1;
      end
    end
  end

  // Next list state and status.
  always_comb begin
    prev_offset_nxt = prev_offset_r;
    budget_nxt      = budget_cur;
    seen_mask_nxt   = seen_upd;
    at_first_nxt    = at_first_r;
    held_error_nxt  = held_error_r;
    if (held_error_r == ST_OK) begin
      at_first_nxt = 1'b0;
      if (entry_err != ST_OK) begin
        held_error_nxt = entry_err;
      end else begin
        prev_offset_nxt = s1_offset_r;
        if (is_data) begin
          budget_nxt = budget_cur - s1_items_r;
        end
      end
    end
    if (s1_last_r && held_error_nxt == ST_OK) begin
      held_error_nxt = miss_err;
    end
    out_status_nxt = held_error_nxt;
    // Clear everything for the next list once the verdict is out.
    if (s1_last_r) begin
      prev_offset_nxt = '0;
      budget_nxt      = '0;
      seen_mask_nxt   = '0;
      at_first_nxt    = 1'b1;
      held_error_nxt  = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_offset_r <= '0;
      budget_r      <= '0;
      seen_mask_r   <= '0;
      at_first_r    <= 1'b1;
      held_error_r  <= ST_OK;
    end else if (load) begin
      prev_offset_r <= prev_offset_nxt;
      budget_r      <= budget_nxt;
      seen_mask_r   <= seen_mask_nxt;
      at_first_r    <= at_first_nxt;
      held_error_r  <= held_error_nxt;
    end
  end

  // Result register: hold until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= out_status_nxt;
      out_seen_r   <= seen_upd;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_seen_r, out_status_r};

  // A list verdict leaves the state fully cleared.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && s1_last_r) |=>
      (at_first_r && held_error_r == ST_OK && seen_mask_r == '0))
    else $error("list state not cleared after final entry");

  // A held error sticks for the rest of the list.
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !s1_last_r && held_error_r != ST_OK) |=>
      (held_error_r == $past(held_error_r)))
    else $error("held error changed mid-list");

  // With an error held, the seen mask stops growing.
  a_mask_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !s1_last_r && held_error_r != ST_OK) |=>
      (seen_mask_r == $past(seen_mask_r)))
    else $error("seen mask changed while an error is held");

  // Missing-section codes only appear on a list verdict.
  a_miss_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_status_r <= ST_DUPLICATE))
    else $error("missing-section status before the final entry");

  // Status never leaves the defined code range.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r <= ST_MISS_CLASSDEF))
    else $error("status code out of range");

endmodule

// ----- sim/dex_map_list_checker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dex_map_list_checker_tb: self-checking bench for the map-list checker
// Streams directed and random map lists through the block under random
// backpressure, predicts each result in a scoreboard and compares every field.
// ----------------------------------------------------------------------------
module dex_map_list_checker_tb;
  import dmlc_pkg::*;

  // Type codes used by name in the stimulus
  localparam logic [TYPE_W-1:0] CODE_HEADER    = 16'h0000;
  localparam logic [TYPE_W-1:0] CODE_STRING    = 16'h0001;
  localparam logic [TYPE_W-1:0] CODE_DATA1     = 16'h2001;
  // Codes that decode to no section
  localparam logic [TYPE_W-1:0] CODE_PAST_IDS  = 16'h0007;
  localparam logic [TYPE_W-1:0] CODE_GAP       = 16'h0008;
  localparam logic [TYPE_W-1:0] CODE_BELOW_MAP = 16'h0FFF;
  localparam logic [TYPE_W-1:0] CODE_PAST_MAPS = 16'h1004;
  localparam logic [TYPE_W-1:0] CODE_PAST_DATA = 16'h2007;
  localparam logic [TYPE_W-1:0] CODE_TOP       = 16'hFFFF;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  localparam int SEEN_DATA0      = 11;    // seen bit of the first 0x2000-group code
  localparam int IDLE_PCT        = 18;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 5000;
  localparam int PHASE_ITEMS     = 250;
  localparam int N_PHASES        = 7;
  localparam int MAX_PRINTED     = 100;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct {
    logic [TYPE_W-1:0]  code;
    logic [COUNT_W-1:0] items;
    logic [OFFS_W-1:0]  offs;
    logic               last;
  } map_entry_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                done;
    logic [SEEN_W-1:0]   seen;
  } verdict_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers and the per-list state
  // --------------------------------------------------------------------------
  class map_list_scoreboard;
    logic [31:0]         file_size;
    logic [31:0]         data_size;
    logic [ID_N-1:0]     id_decl;
    logic [OFFS_W-1:0]   prev_offs;
    logic [COUNT_W-1:0]  budget;
    logic [SEEN_W-1:0]   seen;
    logic                first_entry;
    logic [STATUS_W-1:0] held;
    verdict_t            expected_verdicts[$];
    int                  errors;

    function new();
      file_size = '0;
      data_size = '0;
      id_decl   = '0;
      errors    = 0;
      clear_list();
    endfunction

    function void clear_list();
      prev_offs   = '0;
      budget      = '0;
      seen        = '0;
      first_entry = 1'b1;
      held        = ST_OK;
    endfunction

    function void mirror_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_FILE_SIZE: file_size = data;
        REG_DATA_SIZE: data_size = data;
        REG_ID_DECL:   id_decl   = data[ID_N-1:0];
        default: ;
      endcase
    endfunction

    // One-hot seen bit of a type code; zero when the code names no section
    function logic [SEEN_W-1:0] section_bit(logic [TYPE_W-1:0] code);
      logic [SEEN_W-1:0] hit;
      hit = '0;
      if (code <= CODE_LAST_ID) begin
        hit[code[2:0]] = 1'b1;
      end else if (code >= CODE_MAP && code <= CODE_MAP + 16'd3) begin
        hit[SEEN_MAP + int'(code[1:0])] = 1'b1;
      end else if (code >= CODE_DATA0 && code <= CODE_DATA6) begin
        hit[SEEN_DATA0 + int'(code[2:0])] = 1'b1;
      end
      return hit;
    endfunction

    // Work out the verdict that one accepted entry must produce
    function void note_entry(map_entry_t e);
      logic [SEEN_W-1:0]   hit;
      logic [STATUS_W-1:0] err;
      logic                is_data;
      verdict_t            v;
      is_data = e.code > CODE_LAST_ID;
      if (first_entry) budget = data_size;
      if (held == ST_OK) begin
        hit = section_bit(e.code);
        err = ST_OK;
        if (!first_entry && prev_offs >= e.offs) err = ST_ORDER;
        else if (e.offs >= file_size) err = ST_PAST_END;
        else if (is_data && e.items > budget) err = ST_TOO_MANY;
        else if (hit == '0) err = ST_UNKNOWN;
        else if ((seen & hit) != '0) err = ST_DUPLICATE;
        if (err != ST_OK) begin
          held = err;
        end else begin
          if (is_data) budget = budget - e.items;
          seen      = seen | hit;
          prev_offs = e.offs;
        end
        first_entry = 1'b0;
      end
      // Required sections: walk down so the lowest status code wins
      if (e.last && held == ST_OK) begin
        if (!seen[SEEN_HEADER]) begin
          held = ST_MISS_HEADER;
        end else if (!seen[SEEN_MAP]) begin
          held = ST_MISS_MAP;
        end else begin
          for (int k = ID_N - 1; k >= 0; k--)
            if (id_decl[k] && !seen[SEEN_ID0 + k]) held = ST_MISS_ID0 + STATUS_W'(k);
        end
      end
      v.status = held;
      v.done   = e.last;
      v.seen   = seen;
      expected_verdicts.push_back(v);
      if (e.last) clear_list();
    endfunction

    task report(string what);
      // Cap the log; every failure still counts
      if (errors < MAX_PRINTED) $display("[%0t] ERROR %s", $time, what);
      errors++;
    endtask

    task check_verdict(logic [STATUS_W-1:0] status, logic done, logic [SEEN_W-1:0] mask);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("result with nothing pending: status=%0d done=%0b seen=%05h",
                         status, done, mask));
        return;
      end
      v = expected_verdicts.pop_front();
      if (status !== v.status)
        report($sformatf("status got %0d want %0d", status, v.status));
      if (done !== v.done)
        report($sformatf("list_done got %0b want %0b", done, v.done));
      if (mask !== v.seen)
        report($sformatf("sections_seen got %05h want %05h", mask, v.seen));
    endtask

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  map_list_scoreboard sb;
  map_entry_t         list_q[$];
  bit                 calm;          // no idling on either side
  bit                 hold_off_req;  // ask the receiver for one long stall
  int                 sent;

  dex_map_list_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Code of the section that owns a given seen bit
  function automatic logic [TYPE_W-1:0] code_of(input int b);
    if (b < SEEN_MAP) return TYPE_W'(b);
    if (b < SEEN_DATA0) return CODE_MAP + TYPE_W'(b - SEEN_MAP);
    return CODE_DATA0 + TYPE_W'(b - SEEN_DATA0);
  endfunction

  function automatic logic [TYPE_W-1:0] odd_code();
    case ($urandom_range(6))
      0:       return CODE_PAST_IDS;
      1:       return CODE_GAP;
      2:       return CODE_BELOW_MAP;
      3:       return CODE_PAST_MAPS;
      4:       return CODE_PAST_DATA;
      5:       return CODE_TOP;
      default: return TYPE_W'($urandom);
    endcase
  endfunction

  function automatic void add(input logic [TYPE_W-1:0] code, input logic [31:0] items,
                              input logic [31:0] offs, input logic last);
    map_entry_t e;
    e.code  = code;
    e.items = items;
    e.offs  = offs;
    e.last  = last;
    list_q.push_back(e);
  endfunction

  // Build one map list into list_q. Most lists are well formed with random
  // content; some get one defect planted, a few are pure noise.
  function automatic void build_list(input logic [31:0] fs, input logic [31:0] ds);
    logic [TYPE_W-1:0] codes[$];
    logic [TYPE_W-1:0] swap;
    logic [31:0]       offs;
    logic [31:0]       share;
    int                j;
    int                r;
    map_entry_t        e;
    list_q.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(5, 1)) begin
        case ($urandom_range(2))
          0:       e.code = TYPE_W'($urandom);
          1:       e.code = code_of($urandom_range(SEEN_W - 1));
          default: e.code = odd_code();
        endcase
        e.items = $urandom;
        e.offs  = $urandom;
        e.last  = 1'b0;
        list_q.push_back(e);
      end
    end else begin
      // Pick a random subset of sections; keep the map section most of the time
      for (int b = SEEN_ID0; b < SEEN_W; b++)
        if (b == SEEN_MAP ? $urandom_range(9) != 0 : $urandom_range(1) == 1)
          codes.push_back(code_of(b));
      for (int i = codes.size() - 1; i > 0; i--) begin
        j        = $urandom_range(i);
        swap     = codes[i];
        codes[i] = codes[j];
        codes[j] = swap;
      end
      // Header leads the list usually, sits elsewhere or is dropped now and then
      r = $urandom_range(19);
      if (r == 1 && codes.size() > 0) codes.insert($urandom_range(codes.size() - 1), CODE_HEADER);
      else if (r != 0 || codes.size() == 0) codes.push_front(CODE_HEADER);
      // Keep the data counts well inside the budget
      share = ds / 24;
      case ($urandom_range(3))
        0:       offs = '0;
        1:       offs = fs - 32'h0010_0000 - $urandom_range(32'hFFFF);
        default: offs = $urandom_range(32'hFFFF);
      endcase
      foreach (codes[i]) begin
        if (i > 0) offs = offs + $urandom_range(4096, 1);
        e.code  = codes[i];
        e.items = (codes[i] > CODE_LAST_ID) ? $urandom_range(share) : $urandom;
        e.offs  = offs;
        e.last  = 1'b0;
        list_q.push_back(e);
      end
      // Plant one defect in about a fifth of the lists
      if ($urandom_range(4) == 0) begin
        j = $urandom_range(list_q.size() - 1);
        case ($urandom_range(4))
          0: if (j > 0) list_q[j].offs = list_q[j-1].offs - $urandom_range(2);
          1: list_q[j].offs = (fs > ALL_ONES - 32'd1000) ? ALL_ONES : fs + $urandom_range(1000);
          2: begin
            if (list_q[j].code <= CODE_LAST_ID) list_q[j].code = CODE_PAST_DATA;
            list_q[j].items = (ds == ALL_ONES) ? ALL_ONES : ds + $urandom_range(ALL_ONES - ds, 1);
          end
          3: list_q[j].code = odd_code();
          default: if (j > 0) list_q[j].code = list_q[$urandom_range(j - 1)].code;
        endcase
      end
    end
    list_q[list_q.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers (all called at a falling edge, return at a falling edge)
  // --------------------------------------------------------------------------
  task automatic push_entry(input map_entry_t e);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {e.offs, e.items, e.code};
    in_tlast  <= e.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_entry(e);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_list();
    foreach (list_q[i]) push_entry(list_q[i]);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.mirror_reg(addr, data);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [31:0] fs, input logic [31:0] ds,
                              input logic [ID_N-1:0] decl, input bit poke_unused);
    write_reg(REG_FILE_SIZE, fs);
    write_reg(REG_DATA_SIZE, ds);
    if (poke_unused) write_reg(REG_UNUSED, $urandom);
    write_reg(REG_ID_DECL, CFG_DATA_W'(decl));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending result, then cover the pipeline latency
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic directed_lists();
    program_regs(ALL_ONES, ALL_ONES, 6'h3F, 1'b0);
    list_q.delete();
    add(CODE_MAP, '0, '0, 1'b1);                   // map alone: header missing
    add(CODE_HEADER, ALL_ONES, '0, 1'b1);          // header alone: map missing
    add(CODE_HEADER, '0, '0, 1'b0);                // string section declared, absent
    add(CODE_MAP, '0, 32'hFFFF_FFFE, 1'b1);
    add(CODE_HEADER, '0, 32'h10, 1'b0);            // equal offsets: out of order,
    add(CODE_STRING, 32'd1, 32'h10, 1'b0);         // then held to the end
    add(CODE_DATA0, 32'd1, 32'h20, 1'b1);
    add(CODE_PAST_IDS, '0, '0, 1'b0);              // codes just past the id group
    add(CODE_GAP, '0, 32'd4, 1'b1);
    add(CODE_HEADER, '0, '0, 1'b0);                // header twice
    add(CODE_HEADER, '0, 32'd8, 1'b1);
    send_list();
    settle();
    program_regs(32'h100, 32'd5, 6'h20, 1'b0);
    list_q.delete();
    add(CODE_HEADER, '0, '0, 1'b0);                // unknown code over budget:
    add(CODE_TOP, 32'd6, 32'd4, 1'b0);             // budget check comes first
    add(CODE_MAP, '0, 32'd8, 1'b1);
    add(CODE_HEADER, '0, '0, 1'b0);                // budget used up exactly,
    add(CODE_DATA1, 32'd5, 32'd4, 1'b0);           // class-def section declared, absent
    add(CODE_MAP, '0, 32'hFF, 1'b1);
    add(CODE_HEADER, '0, 32'h100, 1'b1);           // offset equal to file size
    send_list();
    settle();
    program_regs('0, '0, '0, 1'b0);
    list_q.delete();
    add(CODE_HEADER, '0, '0, 1'b1);                // zero file size: past end
    send_list();
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here
  // --------------------------------------------------------------------------
  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Check every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_verdict(out_tdata[STATUS_W-1:0], out_tlast, out_tdata[STATUS_W +: SEEN_W]);
  end

  // Watchdog: end the run if no request or result moves for too long
  initial begin : watchdog
    int still;
    still = 0;
    while (still < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) still = 0;
      else still++;
    end
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0]     fs;
    logic [31:0]     ds;
    logic [ID_N-1:0] decl;
    int              goal;
    sb           = new();
    rst_n        = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    in_tvalid    = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    sent         = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_lists();

    // Random phases; reprogram only once the block has drained
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          fs   = ALL_ONES;
          ds   = ALL_ONES;
          decl = 6'h3F;
        end
        3: begin
          fs   = ALL_ONES;
          ds   = '0;
          decl = '0;
        end
        default: begin
          fs   = $urandom_range(ALL_ONES, 32'h0100_0000);
          ds   = $urandom_range(1) ? $urandom : $urandom_range(4096);
          decl = ID_N'($urandom_range(63));
        end
      endcase
      calm = (p == 2);
      program_regs(fs, ds, decl, p == 1);
      // Stall the receiver long enough to back up the input side
      if (p == 4) hold_off_req = 1'b1;
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        build_list(fs, ds);
        send_list();
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dmlc_pkg.sv
rtl/dex_map_list_checker.sv
sim/dex_map_list_checker_tb.sv
